// ===== src/psd_pkg.sv =====
// ============================================================================
// psd_pkg
// Shared widths and types for the point-to-segment distance pipeline.
// ============================================================================
package psd_pkg;

	// Base settings
	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 8;
	localparam int DIST_W     = 34;

	// Derived widths
	localparam int DIFF_W = COORD_BITS + 1;             // coordinate difference
	localparam int PROD_W = 2 * DIFF_W;                 // product of two differences
	localparam int SUM_W  = PROD_W + 1;                 // dot or cross product
	localparam int MAG_W  = SUM_W;                      // |cross|
	localparam int LEN_W  = PROD_W;                     // squared length
	localparam int NUM_W  = 2 * MAG_W + 2 * FRAC_BITS;  // dividend
	localparam int QUO_W  = LEN_W + 2 * FRAC_BITS;      // squared distance, scaled
	localparam int ROOT_W = QUO_W / 2;                  // square root
	localparam int LO_W   = (MAG_W + 1) / 2;            // low half of |cross|
	localparam int HI_W   = MAG_W - LO_W;               // high half of |cross|

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [LEN_W-1:0]         len_t;
	typedef logic [NUM_W-1:0]         num_t;
	typedef logic [QUO_W-1:0]         quo_t;
	typedef logic [ROOT_W-1:0]        root_t;

endpackage

// ===== src/psd_div.sv =====
// ============================================================================
// psd_div
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// ============================================================================
module psd_div import psd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic in_tag,
	input  num_t num,
	input  len_t den,
	output logic out_valid,
	output logic out_tag,
	output quo_t quo
);

	// Index 0 is the incoming item; 1..QUO_W are registered stages
	len_t rem_s [QUO_W+1];
	quo_t nq_s  [QUO_W+1];   // numerator bits still to use, quotient shifts in
	len_t den_s [QUO_W+1];
	logic tag_s [QUO_W+1];
	logic v_s   [QUO_W+1];

	// High numerator bits are known to be below the divisor
	assign rem_s[0] = len_t'(num[NUM_W-1:QUO_W]);
	assign nq_s[0]  = num[QUO_W-1:0];
	assign den_s[0] = den;
	assign tag_s[0] = in_tag;
	assign v_s[0]   = in_valid;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [LEN_W:0] trial;
		logic [LEN_W:0] diff;
		logic           ge;

		// Shift in one numerator bit, subtract the divisor if it fits
		always_comb begin
			trial = {rem_s[k], nq_s[k][QUO_W-1]};
			diff  = trial - {1'b0, den_s[k]};
			ge    = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
				nq_s[k+1]  <= {nq_s[k][QUO_W-2:0], ge};
				den_s[k+1] <= den_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = v_s[QUO_W];
	assign out_tag   = tag_s[QUO_W];
	assign quo       = nq_s[QUO_W];

endmodule

// ===== src/psd_sqrt.sv =====
// ============================================================================
// psd_sqrt
// Pipelined digit-by-digit integer square root: one root bit per stage.
// ============================================================================
module psd_sqrt import psd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  logic  in_tag,
	input  quo_t  radicand,
	output logic  out_valid,
	output logic  out_tag,
	output root_t root
);

	// Index 0 is the incoming item; 1..ROOT_W are registered stages
	logic [ROOT_W:0] rem_s  [ROOT_W+1];
	root_t           root_s [ROOT_W+1];
	quo_t            x_s    [ROOT_W+1];
	logic            tag_s  [ROOT_W+1];
	logic            v_s    [ROOT_W+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign x_s[0]    = radicand;
	assign tag_s[0]  = in_tag;
	assign v_s[0]    = in_valid;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [ROOT_W+2:0] rem2;
		logic [ROOT_W+2:0] trial;
		logic [ROOT_W+2:0] diff;
		logic              ge;

		// Bring down two radicand bits, try root bit set
		always_comb begin
			rem2  = {rem_s[k], x_s[k][QUO_W-1 -: 2]};
			trial = {1'b0, root_s[k], 2'b01};
			diff  = rem2 - trial;
			ge    = rem2 >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[ROOT_W:0] : rem2[ROOT_W:0];
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
				x_s[k+1]    <= {x_s[k][QUO_W-3:0], 2'b00};
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign out_tag   = tag_s[ROOT_W];
	assign root      = root_s[ROOT_W];

endmodule

// ===== src/point_segment_distance.sv =====
// ============================================================================
// point_segment_distance
// Distance from a point to a 2-D segment, unsigned Q.8, truncated.
// ============================================================================
//
//  channel  valid         stall         payload
//  -------  ------------  ------------  ------------------------------------
//  item     item_valid    item_stall    head_x/y, tail_x/y, point_x/y
//  result   result_valid  result_stall  distance_q8, endpoint_case
//
//  One item per cycle while no result is held under result_stall. The
//  pipeline has six front stages, one divider stage per quotient bit
//  and one square-root stage per root bit.
//  Reset clears only the valid bits; no clearing pass.
//  While a result is held under result_stall the whole pipeline freezes
//  and item_stall is raised; nothing is dropped or repeated.
//
module point_segment_distance import psd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic [COORD_BITS-1:0]  head_x,
	input  logic [COORD_BITS-1:0]  head_y,
	input  logic [COORD_BITS-1:0]  tail_x,
	input  logic [COORD_BITS-1:0]  tail_y,
	input  logic [COORD_BITS-1:0]  point_x,
	input  logic [COORD_BITS-1:0]  point_y,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [DIST_W-1:0]      distance_q8,
	output logic                   endpoint_case
);

	logic en;

	// Global advance: freeze only while a result is held back
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	// Valid bits of the front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: edge and offset vectors
	diff_t ex_s1, ey_s1, wx_s1, wy_s1, ux_s1, uy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1 <= diff_t'($signed(tail_x))  - diff_t'($signed(head_x));
			ey_s1 <= diff_t'($signed(tail_y))  - diff_t'($signed(head_y));
			wx_s1 <= diff_t'($signed(point_x)) - diff_t'($signed(head_x));
			wy_s1 <= diff_t'($signed(point_y)) - diff_t'($signed(head_y));
			ux_s1 <= diff_t'($signed(point_x)) - diff_t'($signed(tail_x));
			uy_s1 <= diff_t'($signed(point_y)) - diff_t'($signed(tail_y));
		end
	end

	// Stage 2: all products, one multiplier each
	prod_t wxex_s2, wyey_s2, uxex_s2, uyey_s2, exwy_s2, eywx_s2;
	prod_t exex_s2, eyey_s2, wxwx_s2, wywy_s2, uxux_s2, uyuy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			wxex_s2 <= wx_s1 * ex_s1;
			wyey_s2 <= wy_s1 * ey_s1;
			uxex_s2 <= ux_s1 * ex_s1;
			uyey_s2 <= uy_s1 * ey_s1;
			exwy_s2 <= ex_s1 * wy_s1;
			eywx_s2 <= ey_s1 * wx_s1;
			exex_s2 <= ex_s1 * ex_s1;
			eyey_s2 <= ey_s1 * ey_s1;
			wxwx_s2 <= wx_s1 * wx_s1;
			wywy_s2 <= wy_s1 * wy_s1;
			uxux_s2 <= ux_s1 * ux_s1;
			uyuy_s2 <= uy_s1 * uy_s1;
		end
	end

	// Stage 3: dot products, cross product, squared lengths
	sum_t dot_h_s3, dot_t_s3, cross_s3;
	len_t len_s3, dh_s3, dt_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			dot_h_s3 <= sum_t'(wxex_s2) + sum_t'(wyey_s2);
			dot_t_s3 <= sum_t'(uxex_s2) + sum_t'(uyey_s2);
			cross_s3 <= sum_t'(exwy_s2) - sum_t'(eywx_s2);
			len_s3   <= len_t'(exex_s2) + len_t'(eyey_s2);
			dh_s3    <= len_t'(wxwx_s2) + len_t'(wywy_s2);
			dt_s3    <= len_t'(uxux_s2) + len_t'(uyuy_s2);
		end
	end

	// Stage 4: case decision, |cross|, nearer endpoint
	logic perp_s4;
	mag_t cmag_s4;
	len_t len_s4, mind_s4;
	logic perp_c;

	// Foot on the segment: w.e >= 0 and u.e <= 0, segment not a point
	assign perp_c = (len_s3 != '0) && !dot_h_s3[SUM_W-1]
	                && (dot_t_s3[SUM_W-1] || dot_t_s3 == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			perp_s4 <= perp_c;
			cmag_s4 <= mag_t'(cross_s3[SUM_W-1] ? -cross_s3 : cross_s3);
			len_s4  <= len_s3;
			mind_s4 <= (dh_s3 <= dt_s3) ? dh_s3 : dt_s3;
		end
	end

	// Stage 5: partial products of |cross|^2
	logic [2*HI_W-1:0]    pp_hh_s5;
	logic [HI_W+LO_W-1:0] pp_hl_s5;
	logic [2*LO_W-1:0]    pp_ll_s5;
	logic                 perp_s5;
	len_t                 len_s5, mind_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_hh_s5 <= cmag_s4[MAG_W-1:LO_W] * cmag_s4[MAG_W-1:LO_W];
			pp_hl_s5 <= cmag_s4[MAG_W-1:LO_W] * cmag_s4[LO_W-1:0];
			pp_ll_s5 <= cmag_s4[LO_W-1:0] * cmag_s4[LO_W-1:0];
			perp_s5  <= perp_s4;
			len_s5   <= len_s4;
			mind_s5  <= mind_s4;
		end
	end

	// Stage 6: dividend and divisor; endpoint case divides by one
	num_t num_s6;
	len_t den_s6;
	logic perp_s6;
	num_t csq;

	assign csq = (num_t'(pp_hh_s5) << (2 * LO_W)) + (num_t'(pp_hl_s5) << (LO_W + 1))
	             + num_t'(pp_ll_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6  <= perp_s5 ? (csq << (2 * FRAC_BITS))
			                   : (num_t'(mind_s5) << (2 * FRAC_BITS));
			den_s6  <= perp_s5 ? len_s5 : len_t'(1);
			perp_s6 <= perp_s5;
		end
	end

	// Divider and square root
	logic div_valid, div_tag;
	quo_t div_quo;
	logic sq_tag;
	root_t sq_root;

	psd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_tag    (!perp_s6),
		.num       (num_s6),
		.den       (den_s6),
		.out_valid (div_valid),
		.out_tag   (div_tag),
		.quo       (div_quo)
	);

	psd_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.in_tag    (div_tag),
		.radicand  (div_quo),
		.out_valid (result_valid),
		.out_tag   (sq_tag),
		.root      (sq_root)
	);

	assign distance_q8   = DIST_W'(sq_root);
	assign endpoint_case = sq_tag;

	// Checks
	a_s1_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(en && item_valid) |=> v_s1)
		else $error("accepted item did not enter stage 1");

	a_perp_len: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && perp_s4) |-> (len_s4 != '0))
		else $error("perpendicular case on a degenerate segment");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (den_s6 != '0))
		else $error("zero divisor entering divider");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (v_s6 == $past(v_s6)))
		else $error("front stage moved while frozen");

endmodule
